@@ hw/rtl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants
// Request payloads, configuration bundle, opcode and mode codes for the
// feeder shot controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

  // opcodes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_TRIGGER  = 3'd1;
  localparam logic [2:0] OP_SET_CMD  = 3'd2;
  localparam logic [2:0] OP_SET_FRIC = 3'd3;
  localparam logic [2:0] OP_ENABLE   = 3'd4;
  localparam logic [2:0] OP_DISABLE  = 3'd5;

  // operating modes
  localparam logic [1:0] MODE_ARMING = 2'd0;
  localparam logic [1:0] MODE_READY  = 2'd1;
  localparam logic [1:0] MODE_JAMMED = 2'd2;

  // shot commands
  localparam logic [1:0] CMD_STOP   = 2'd0;
  localparam logic [1:0] CMD_SINGLE = 2'd1;
  localparam logic [1:0] CMD_CONT   = 2'd2;

  // trigger switch events
  localparam logic [1:0] TRIG_PRESSED  = 2'd1;
  localparam logic [1:0] TRIG_RELEASED = 2'd2;

  // register indexes
  localparam logic [2:0] REG_JAM_CURRENT    = 3'd0;
  localparam logic [2:0] REG_JAM_SPEED      = 3'd1;
  localparam logic [2:0] REG_JAM_CLEAR_MS   = 3'd2;
  localparam logic [2:0] REG_JAM_CONFIRM_MS = 3'd3;
  localparam logic [2:0] REG_FEED_SPEED     = 3'd4;
  localparam logic [2:0] REG_FRIC_READY     = 3'd5;
  localparam logic [2:0] REG_FRIC_FLOOR     = 3'd6;
  localparam logic [2:0] REG_FRIC_CEILING   = 3'd7;

  // feed speed write limits
  localparam logic [11:0] FEED_MIN = 12'd1000;
  localparam logic [11:0] FEED_MAX = 12'd2500;

  // register reset values
  localparam logic [14:0]        RST_JAM_CURRENT    = 15'd2000;
  localparam logic signed [15:0] RST_JAM_SPEED      = -16'sd1000;
  localparam logic [15:0]        RST_JAM_CLEAR_MS   = 16'd500;
  localparam logic [15:0]        RST_JAM_CONFIRM_MS = 16'd100;
  localparam logic [11:0]        RST_FEED_SPEED     = 12'd1500;
  localparam logic [15:0]        RST_FRIC_READY     = 16'd1200;
  localparam logic [15:0]        RST_FRIC_FLOOR     = 16'd1000;
  localparam logic [15:0]        RST_FRIC_CEILING   = 16'd2000;

  typedef struct packed {
    logic [14:0]        jam_current;
    logic signed [15:0] jam_speed;
    logic [15:0]        jam_clear_ms;
    logic [15:0]        jam_confirm_ms;
    logic [11:0]        feed_speed;
    logic [15:0]        fric_ready_speed;
    logic [15:0]        fric_floor;
    logic [15:0]        fric_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        now_ms;
    logic [1:0]         trigger_event;
    logic signed [15:0] motor_current;
    logic [1:0]         command;
    logic [15:0]        shot_request;
    logic [15:0]        fric_target_a;
    logic [15:0]        fric_target_b;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] feed_speed_target;
    logic               feed_enable;
    logic [15:0]        fric_out_a;
    logic [15:0]        fric_out_b;
    logic [1:0]         mode;
    logic [1:0]         command_now;
    logic [31:0]        shots_fired;
  } out_item_t;

endpackage

@@ hw/rtl/fsc_cfg.sv @@
// ----------------------------------------------------------------------------
// fsc_cfg: configuration register file
// APB-style write/read port holding the jam, feed and friction settings.
// ----------------------------------------------------------------------------
module fsc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fsc_pkg::cfg_t      cfg_o
);

  fsc_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr_en;
  logic [11:0]   feed_raw;
  logic [11:0]   feed_clamped;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  assign feed_raw     = pwdata[11:0];
  assign feed_clamped = (feed_raw < fsc_pkg::FEED_MIN) ? fsc_pkg::FEED_MIN :
                        (feed_raw > fsc_pkg::FEED_MAX) ? fsc_pkg::FEED_MAX : feed_raw;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        fsc_pkg::REG_JAM_CURRENT:    cfg_d.jam_current      = pwdata[14:0];
        fsc_pkg::REG_JAM_SPEED:      cfg_d.jam_speed        = $signed(pwdata[15:0]);
        fsc_pkg::REG_JAM_CLEAR_MS:   cfg_d.jam_clear_ms     = pwdata[15:0];
        fsc_pkg::REG_JAM_CONFIRM_MS: cfg_d.jam_confirm_ms   = pwdata[15:0];
        fsc_pkg::REG_FEED_SPEED:     cfg_d.feed_speed       = feed_clamped;
        fsc_pkg::REG_FRIC_READY:     cfg_d.fric_ready_speed = pwdata[15:0];
        fsc_pkg::REG_FRIC_FLOOR:     cfg_d.fric_floor       = pwdata[15:0];
        fsc_pkg::REG_FRIC_CEILING:   cfg_d.fric_ceiling     = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jam_current      <= fsc_pkg::RST_JAM_CURRENT;
      cfg_q.jam_speed        <= fsc_pkg::RST_JAM_SPEED;
      cfg_q.jam_clear_ms     <= fsc_pkg::RST_JAM_CLEAR_MS;
      cfg_q.jam_confirm_ms   <= fsc_pkg::RST_JAM_CONFIRM_MS;
      cfg_q.feed_speed       <= fsc_pkg::RST_FEED_SPEED;
      cfg_q.fric_ready_speed <= fsc_pkg::RST_FRIC_READY;
      cfg_q.fric_floor       <= fsc_pkg::RST_FRIC_FLOOR;
      cfg_q.fric_ceiling     <= fsc_pkg::RST_FRIC_CEILING;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      fsc_pkg::REG_JAM_CURRENT:    prdata = {17'd0, cfg_q.jam_current};
      fsc_pkg::REG_JAM_SPEED:      prdata = {{16{cfg_q.jam_speed[15]}}, cfg_q.jam_speed};
      fsc_pkg::REG_JAM_CLEAR_MS:   prdata = {16'd0, cfg_q.jam_clear_ms};
      fsc_pkg::REG_JAM_CONFIRM_MS: prdata = {16'd0, cfg_q.jam_confirm_ms};
      fsc_pkg::REG_FEED_SPEED:     prdata = {20'd0, cfg_q.feed_speed};
      fsc_pkg::REG_FRIC_READY:     prdata = {16'd0, cfg_q.fric_ready_speed};
      fsc_pkg::REG_FRIC_FLOOR:     prdata = {16'd0, cfg_q.fric_floor};
      fsc_pkg::REG_FRIC_CEILING:   prdata = {16'd0, cfg_q.fric_ceiling};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

  // feed speed always inside its legal window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_q.feed_speed >= fsc_pkg::FEED_MIN) && (cfg_q.feed_speed <= fsc_pkg::FEED_MAX))
    else $error("feed speed outside limits");

  // settings change only through a completed write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(wr_en) |-> $stable(cfg_q))
    else $error("config changed without write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

@@ hw/rtl/fsc_core.sv @@
// ----------------------------------------------------------------------------
// fsc_core: controller state and per-request update
// Holds feeder/friction state and computes the next state for one request.
// ----------------------------------------------------------------------------
module fsc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  fsc_pkg::in_item_t    item_i,
  input  fsc_pkg::cfg_t        cfg_i,
  output fsc_pkg::out_item_t   res_o
);

  logic [1:0]  mode_q, mode_d;
  logic [1:0]  cmd_q, cmd_d;
  logic [31:0] shot_cnt_q, shot_cnt_d;
  logic [31:0] shot_goal_q, shot_goal_d;
  logic        jam_pend_q, jam_pend_d;
  logic [31:0] jam_start_q, jam_start_d;
  logic [31:0] jam_decl_q, jam_decl_d;
  logic [15:0] spd_q, spd_d;
  logic [15:0] goal_a_q, goal_a_d, goal_b_q, goal_b_d;
  logic [15:0] lvl_a_q, lvl_a_d, lvl_b_q, lvl_b_d;
  logic        reg_on_q, reg_on_d;

  logic        fric_rdy;
  logic        trig_go;
  logic [15:0] feed_spd;
  logic        over_cur;
  logic [31:0] since_start;
  logic [31:0] since_decl;

  assign feed_spd    = {4'd0, cfg_i.feed_speed};
  assign over_cur    = item_i.motor_current > $signed({1'b0, cfg_i.jam_current});
  assign since_start = item_i.now_ms - jam_start_q;

  function automatic logic [15:0] clamp_goal(input logic [15:0] g,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [15:0] r;
    if (g <= lo) begin
      r = lo;
    end else if (g >= hi) begin
      r = hi;
    end else begin
      r = g;
    end
    return r;
  endfunction

  always_comb begin
    mode_d      = mode_q;
    cmd_d       = cmd_q;
    shot_cnt_d  = shot_cnt_q;
    shot_goal_d = shot_goal_q;
    jam_pend_d  = jam_pend_q;
    jam_start_d = jam_start_q;
    jam_decl_d  = jam_decl_q;
    spd_d       = spd_q;
    goal_a_d    = goal_a_q;
    goal_b_d    = goal_b_q;
    lvl_a_d     = lvl_a_q;
    lvl_b_d     = lvl_b_q;
    reg_on_d    = reg_on_q;
    trig_go     = 1'b0;
    fric_rdy    = 1'b0;
    since_decl  = 32'd0;

    case (item_i.opcode)
      fsc_pkg::OP_TICK: begin
        goal_a_d = clamp_goal(goal_a_q, cfg_i.fric_floor, cfg_i.fric_ceiling);
        goal_b_d = clamp_goal(goal_b_q, cfg_i.fric_floor, cfg_i.fric_ceiling);
        // first wheel ramps first
        if (goal_a_d != lvl_a_q) begin
          lvl_a_d = (goal_a_d < lvl_a_q) ? lvl_a_q - 16'd1 : lvl_a_q + 16'd1;
        end else if (goal_b_d != lvl_b_q) begin
          lvl_b_d = (goal_b_d < lvl_b_q) ? lvl_b_q - 16'd1 : lvl_b_q + 16'd1;
        end

        if (over_cur) begin
          if (!jam_pend_q) begin
            jam_pend_d  = 1'b1;
            jam_start_d = item_i.now_ms;
          end else if (since_start > {16'd0, cfg_i.jam_confirm_ms}) begin
            jam_pend_d = 1'b0;
            jam_decl_d = item_i.now_ms;
            mode_d     = fsc_pkg::MODE_JAMMED;
          end
        end else begin
          jam_pend_d = 1'b0;
        end

        fric_rdy   = (lvl_a_d >= cfg_i.fric_ready_speed) &&
                     (lvl_b_d >= cfg_i.fric_ready_speed);
        since_decl = item_i.now_ms - jam_decl_d;

        case (mode_d)
          fsc_pkg::MODE_ARMING: spd_d = feed_spd;
          fsc_pkg::MODE_READY: begin
            if (fric_rdy) begin
              if (cmd_q == fsc_pkg::CMD_SINGLE || cmd_q == fsc_pkg::CMD_CONT) begin
                spd_d = feed_spd;
              end else if (cmd_q == fsc_pkg::CMD_STOP && shot_cnt_q < shot_goal_q) begin
                cmd_d = fsc_pkg::CMD_SINGLE;
              end
            end else begin
              cmd_d = fsc_pkg::CMD_STOP;
            end
          end
          fsc_pkg::MODE_JAMMED: begin
            spd_d   = cfg_i.jam_speed;
            trig_go = since_decl > {16'd0, cfg_i.jam_clear_ms};
          end
          default: ;
        endcase

        reg_on_d = fric_rdy;
      end
      fsc_pkg::OP_TRIGGER: trig_go = 1'b1;
      fsc_pkg::OP_SET_CMD: begin
        if (item_i.command == fsc_pkg::CMD_STOP || item_i.command == fsc_pkg::CMD_SINGLE ||
            item_i.command == fsc_pkg::CMD_CONT) begin
          cmd_d = item_i.command;
          if (item_i.command == fsc_pkg::CMD_SINGLE) begin
            shot_goal_d = shot_cnt_q + {16'd0, item_i.shot_request};
          end
        end
      end
      fsc_pkg::OP_SET_FRIC: begin
        goal_a_d = item_i.fric_target_a;
        goal_b_d = item_i.fric_target_b;
      end
      fsc_pkg::OP_ENABLE: reg_on_d = 1'b1;
      fsc_pkg::OP_DISABLE: begin
        goal_a_d    = 16'd0;
        goal_b_d    = 16'd0;
        reg_on_d    = 1'b0;
        shot_goal_d = shot_cnt_q;
      end
      default: ;
    endcase

    // trigger switch handling
    if (trig_go) begin
      if (item_i.trigger_event == fsc_pkg::TRIG_PRESSED) begin
        spd_d  = 16'd0;
        mode_d = fsc_pkg::MODE_READY;
      end else if (item_i.trigger_event == fsc_pkg::TRIG_RELEASED) begin
        spd_d  = feed_spd;
        mode_d = fsc_pkg::MODE_ARMING;
        if (cmd_q == fsc_pkg::CMD_SINGLE) begin
          shot_cnt_d = shot_cnt_q + 32'd1;
          cmd_d      = fsc_pkg::CMD_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= fsc_pkg::MODE_ARMING;
      cmd_q       <= fsc_pkg::CMD_STOP;
      shot_cnt_q  <= 32'd0;
      shot_goal_q <= 32'd0;
      jam_pend_q  <= 1'b0;
      jam_start_q <= 32'd0;
      jam_decl_q  <= 32'd0;
      spd_q       <= 16'd0;
      goal_a_q    <= 16'd0;
      goal_b_q    <= 16'd0;
      lvl_a_q     <= 16'd0;
      lvl_b_q     <= 16'd0;
      reg_on_q    <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      cmd_q       <= cmd_d;
      shot_cnt_q  <= shot_cnt_d;
      shot_goal_q <= shot_goal_d;
      jam_pend_q  <= jam_pend_d;
      jam_start_q <= jam_start_d;
      jam_decl_q  <= jam_decl_d;
      spd_q       <= spd_d;
      goal_a_q    <= goal_a_d;
      goal_b_q    <= goal_b_d;
      lvl_a_q     <= lvl_a_d;
      lvl_b_q     <= lvl_b_d;
      reg_on_q    <= reg_on_d;
    end
  end

  assign res_o.feed_speed_target = spd_d;
  assign res_o.feed_enable       = reg_on_d;
  assign res_o.fric_out_a        = lvl_a_d;
  assign res_o.fric_out_b        = lvl_b_d;
  assign res_o.mode              = mode_d;
  assign res_o.command_now       = cmd_d;
  assign res_o.shots_fired       = shot_cnt_d;

  // one wheel ramps per tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((lvl_a_q != $past(lvl_a_q)) && (lvl_b_q != $past(lvl_b_q))))
    else $error("both friction levels moved at once");

  // shot counter only advances by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shot_cnt_q == $past(shot_cnt_q)) || (shot_cnt_q == $past(shot_cnt_q) + 32'd1))
    else $error("shot counter jumped");

  // entering jam clears the pending flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == fsc_pkg::MODE_JAMMED && $past(mode_q) != fsc_pkg::MODE_JAMMED) |-> !jam_pend_q)
    else $error("jam pending left set on jam entry");

  // state moves only on a processed request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(step_i) |-> ($stable(mode_q) && $stable(shot_cnt_q) && $stable(lvl_a_q)))
    else $error("state changed without request");

endmodule

@@ hw/rtl/feeder_shot_controller.sv @@
// ----------------------------------------------------------------------------
// feeder_shot_controller: projectile feeder and friction wheel controller
// Path: an accepted request waits in the input register; once processed, its
// result from the core is written to the result register and offered.
// Throughput: one request per cycle unless a result is held; out_ready_i
// reaches in_ready_o via the step term, so the input stalls in the same cycle.
// Reset: asynchronous active low; settings return to defaults, mode arming,
// command stop, counters and friction levels zero, no request in flight.
// ----------------------------------------------------------------------------
module feeder_shot_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fsc_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fsc_pkg::out_item_t   out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  fsc_pkg::cfg_t      cfg;
  fsc_pkg::in_item_t  in_item_q;
  fsc_pkg::out_item_t res;
  fsc_pkg::out_item_t out_item_q;
  logic               in_vld_q, in_vld_d;
  logic               out_vld_q, out_vld_d;
  logic               step;

  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  fsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without backpressure");

  // a processed request always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("result lost");

  // a waiting result is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> out_vld_q)
    else $error("result dropped while stalled");

endmodule
